@@ rtl/complex_arithmetic_unit_core_assert.svh @@
// ----------------------------------------------------------------------------
// Complex arithmetic unit assertion macros
// Concurrent assertion wrappers, empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef COMPLEX_ARITHMETIC_UNIT_CORE_ASSERT_SVH
`define COMPLEX_ARITHMETIC_UNIT_CORE_ASSERT_SVH
`ifndef SYNTH
`define CAU_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("cau assertion failed");
`define CAU_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("cau assertion failed");
`else
`define CAU_ASSERT(lbl, clk, rst, prop)
`define CAU_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

@@ rtl/cau_pkg.sv @@
// ----------------------------------------------------------------------------
// Complex arithmetic unit package
// Widths, operation and status codes, cell word type and shared functions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cau_pkg;

   localparam int WIDTH        = 32;
   localparam int FRAC_BITS    = 16;
   localparam int CELL_COUNT   = 32;
   localparam int CORDIC_STEPS = 16;

   typedef logic signed [WIDTH-1:0] data_type;
   typedef logic [3:0]              kind_type;
   typedef logic [1:0]              status_type;

   localparam kind_type KIND_ADD   = 4'd0;
   localparam kind_type KIND_SUB   = 4'd1;
   localparam kind_type KIND_MUL   = 4'd2;
   localparam kind_type KIND_SCALE = 4'd3;
   localparam kind_type KIND_CONJ  = 4'd4;
   localparam kind_type KIND_RECIP = 4'd5;
   localparam kind_type KIND_DIV   = 4'd6;
   localparam kind_type KIND_MAG   = 4'd7;
   localparam kind_type KIND_PHASE = 4'd8;

   localparam status_type ST_OK  = 2'd0;
   localparam status_type ST_SAT = 2'd1;
   localparam status_type ST_DZ  = 2'd2;

   localparam data_type DATA_MAX = 32'sh7fffffff;
   localparam data_type DATA_MIN = 32'sh80000000;
   localparam logic signed [65:0] SAT_HI = 66'sd2147483647;
   localparam logic signed [65:0] SAT_LO = -66'sd2147483648;

   localparam logic signed [19:0] PI_Q      = 20'sd205887;
   localparam logic signed [19:0] HALF_PI_Q = 20'sd102944;

   typedef struct packed {
      logic                vld;
      kind_type            kind;
      data_type            fin_re;
      data_type            fin_im;
      status_type          fin_st;
      logic                dz;
      logic [63:0]         dvs;
      logic [63:0]         rem_re;
      logic [63:0]         rem_im;
      logic [31:0]         low_re;
      logic [31:0]         low_im;
      logic [31:0]         quo_re;
      logic [31:0]         quo_im;
      logic                neg_re;
      logic                neg_im;
      logic                big_re;
      logic                big_im;
      logic [63:0]         sq_src;
      logic [34:0]         sq_rem;
      logic [31:0]         sq_root;
      logic                ph_fix;
      logic signed [35:0]  cx;
      logic signed [35:0]  cy;
      logic signed [19:0]  cz;
   } cau_cell_type;

   function automatic logic signed [65:0] sx66(input logic signed [63:0] v);
      return {{2{v[63]}}, v};
   endfunction

   function automatic logic [32:0] sat66(input logic signed [65:0] v);
      logic [32:0] r;
      if (v > SAT_HI) r = {1'b1, DATA_MAX};
      else if (v < SAT_LO) r = {1'b1, DATA_MIN};
      else r = {1'b0, v[31:0]};
      return r;
   endfunction

   function automatic logic [63:0] abs66(input logic signed [65:0] v);
      logic signed [65:0] a;
      a = (v < 0) ? -v : v;
      return a[63:0];
   endfunction

   function automatic logic signed [19:0] atan_step(input logic [3:0] idx);
      logic signed [19:0] r;
      case (idx)
         4'd0:    r = 20'sd51472;
         4'd1:    r = 20'sd30385;
         4'd2:    r = 20'sd16055;
         4'd3:    r = 20'sd8150;
         4'd4:    r = 20'sd4091;
         4'd5:    r = 20'sd2047;
         4'd6:    r = 20'sd1024;
         4'd7:    r = 20'sd512;
         4'd8:    r = 20'sd256;
         4'd9:    r = 20'sd128;
         4'd10:   r = 20'sd64;
         4'd11:   r = 20'sd32;
         4'd12:   r = 20'sd16;
         4'd13:   r = 20'sd8;
         4'd14:   r = 20'sd4;
         default: r = 20'sd2;
      endcase
      return r;
   endfunction

endpackage

@@ rtl/cau_if.sv @@
// ----------------------------------------------------------------------------
// Complex arithmetic unit channels
// Request and response valid/ready channels with their payload.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface cau_req_if;
   logic               valid;
   logic               ready;
   cau_pkg::kind_type  kind;
   cau_pkg::data_type  a_real;
   cau_pkg::data_type  a_imag;
   cau_pkg::data_type  b_real;
   cau_pkg::data_type  b_imag;
   cau_pkg::data_type  alpha;
   modport source(output valid, kind, a_real, a_imag, b_real, b_imag, alpha,
                  input ready);
   modport sink(input valid, kind, a_real, a_imag, b_real, b_imag, alpha,
                output ready);
endinterface

interface cau_rsp_if;
   logic                valid;
   logic                ready;
   cau_pkg::data_type   res_real;
   cau_pkg::data_type   res_imag;
   cau_pkg::status_type status;
   modport source(output valid, res_real, res_imag, status, input ready);
   modport sink(input valid, res_real, res_imag, status, output ready);
endinterface

@@ rtl/cau_cell.sv @@
// ----------------------------------------------------------------------------
// Complex arithmetic unit cell
// One step of both quotient lanes, one root digit and, while step_idx is below CORDIC_STEPS, one rotation step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cau_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic [4:0]            step_idx,
   input  cau_pkg::cau_cell_type prev_cell,
   output cau_pkg::cau_cell_type next_cell
);
   import cau_pkg::*;

   cau_cell_type cell_ff;
   cau_cell_type cell_in;

   logic [64:0]        r2_re;
   logic [64:0]        r2_im;
   logic               ge_re;
   logic               ge_im;
   logic [34:0]        sr2;
   logic [34:0]        trial;
   logic               sge;
   logic signed [35:0] dx;
   logic signed [35:0] dy;
   logic signed [19:0] da;

   always_comb begin
      cell_in = prev_cell;
      r2_re = {prev_cell.rem_re, prev_cell.low_re[31]};
      r2_im = {prev_cell.rem_im, prev_cell.low_im[31]};
      ge_re = r2_re >= {1'b0, prev_cell.dvs};
      ge_im = r2_im >= {1'b0, prev_cell.dvs};
      cell_in.rem_re = ge_re ? 64'(r2_re - {1'b0, prev_cell.dvs}) : r2_re[63:0];
      cell_in.rem_im = ge_im ? 64'(r2_im - {1'b0, prev_cell.dvs}) : r2_im[63:0];
      cell_in.low_re = {prev_cell.low_re[30:0], 1'b0};
      cell_in.low_im = {prev_cell.low_im[30:0], 1'b0};
      cell_in.quo_re = {prev_cell.quo_re[30:0], ge_re};
      cell_in.quo_im = {prev_cell.quo_im[30:0], ge_im};

      sr2   = {prev_cell.sq_rem[32:0], prev_cell.sq_src[63:62]};
      trial = {1'b0, prev_cell.sq_root, 2'b01};
      sge   = sr2 >= trial;
      cell_in.sq_src  = {prev_cell.sq_src[61:0], 2'b00};
      cell_in.sq_rem  = sge ? sr2 - trial : sr2;
      cell_in.sq_root = {prev_cell.sq_root[30:0], sge};

      dx = prev_cell.cy >>> step_idx[3:0];
      dy = prev_cell.cx >>> step_idx[3:0];
      da = atan_step(step_idx[3:0]);
      if (step_idx < 5'(CORDIC_STEPS)) begin
         if (prev_cell.cy >= 0) begin
            cell_in.cx = prev_cell.cx + dx;
            cell_in.cy = prev_cell.cy - dy;
            cell_in.cz = prev_cell.cz + da;
         end else begin
            cell_in.cx = prev_cell.cx - dx;
            cell_in.cy = prev_cell.cy + dy;
            cell_in.cz = prev_cell.cz - da;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.vld <= 1'b0;
      end else if (en) begin
         cell_ff <= cell_in;
      end
   end

   assign next_cell = cell_ff;

endmodule

@@ rtl/cau_prep.sv @@
// ----------------------------------------------------------------------------
// Complex arithmetic unit front end
// Operand products, then direct results and setup of the cell word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cau_prep (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   cau_req_if.sink               req,
   output cau_pkg::cau_cell_type first_cell
);
   import cau_pkg::*;

   logic               a_vld_ff;
   kind_type           a_kind_ff;
   data_type           a_ar_ff, a_ai_ff, a_br_ff, a_bi_ff;
   logic signed [63:0] a_p0_ff, a_p1_ff, a_p2_ff, a_p3_ff, a_s0_ff, a_s1_ff;

   data_type           mul_b;
   data_type           sq_x, sq_y;
   logic signed [63:0] p0_in, p1_in, p2_in, p3_in, s0_in, s1_in;

   cau_cell_type       b_ff;
   cau_cell_type       b_in;

   logic [32:0]        sr, si;
   logic [63:0]        norm;
   logic [63:0]        m_re, m_im;
   logic signed [65:0] t_re, t_im;
   logic signed [35:0] x0, y0;

   always_comb begin
      mul_b = (req.kind == KIND_SCALE) ? req.alpha : req.b_real;
      sq_x  = (req.kind == KIND_DIV) ? req.b_real : req.a_real;
      sq_y  = (req.kind == KIND_DIV) ? req.b_imag : req.a_imag;
      p0_in = req.a_real * mul_b;
      p1_in = req.a_imag * req.b_imag;
      p2_in = req.a_real * req.b_imag;
      p3_in = req.a_imag * mul_b;
      s0_in = sq_x * sq_x;
      s1_in = sq_y * sq_y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else if (en) begin
         a_vld_ff  <= req.valid;
         a_kind_ff <= req.kind;
         a_ar_ff   <= req.a_real;
         a_ai_ff   <= req.a_imag;
         a_br_ff   <= req.b_real;
         a_bi_ff   <= req.b_imag;
         a_p0_ff   <= p0_in;
         a_p1_ff   <= p1_in;
         a_p2_ff   <= p2_in;
         a_p3_ff   <= p3_in;
         a_s0_ff   <= s0_in;
         a_s1_ff   <= s1_in;
      end
   end

   always_comb begin
      b_in      = '0;
      b_in.vld  = a_vld_ff;
      b_in.kind = a_kind_ff;
      sr        = '0;
      si        = '0;
      t_re      = '0;
      t_im      = '0;
      norm      = $unsigned(a_s0_ff) + $unsigned(a_s1_ff);
      m_re      = '0;
      m_im      = '0;
      x0        = 36'(a_ar_ff);
      y0        = 36'(a_ai_ff);
      b_in.dvs    = norm;
      b_in.dz     = (norm == 64'd0);
      b_in.sq_src = norm;
      unique case (a_kind_ff)
         KIND_ADD: begin
            sr = sat66(66'(a_ar_ff) + 66'(a_br_ff));
            si = sat66(66'(a_ai_ff) + 66'(a_bi_ff));
         end
         KIND_SUB: begin
            sr = sat66(66'(a_ar_ff) - 66'(a_br_ff));
            si = sat66(66'(a_ai_ff) - 66'(a_bi_ff));
         end
         KIND_MUL: begin
            t_re = sx66(a_p0_ff) - sx66(a_p1_ff);
            t_im = sx66(a_p2_ff) + sx66(a_p3_ff);
            sr = sat66(t_re >>> FRAC_BITS);
            si = sat66(t_im >>> FRAC_BITS);
         end
         KIND_SCALE: begin
            sr = sat66(sx66(a_p0_ff) >>> FRAC_BITS);
            si = sat66(sx66(a_p3_ff) >>> FRAC_BITS);
         end
         KIND_CONJ: begin
            sr = {1'b0, a_ar_ff};
            si = sat66(-66'(a_ai_ff));
         end
         KIND_RECIP: begin
            m_re = abs66(66'(a_ar_ff));
            m_im = abs66(66'(a_ai_ff));
            b_in.neg_re = a_ar_ff < 0;
            b_in.neg_im = a_ai_ff > 0;
            b_in.rem_re = m_re;
            b_in.rem_im = m_im;
            b_in.big_re = m_re >= norm;
            b_in.big_im = m_im >= norm;
         end
         KIND_DIV: begin
            t_re = sx66(a_p0_ff) + sx66(a_p1_ff);
            t_im = sx66(a_p3_ff) - sx66(a_p2_ff);
            m_re = abs66(t_re);
            m_im = abs66(t_im);
            b_in.neg_re = t_re < 0;
            b_in.neg_im = t_im < 0;
            b_in.rem_re = {16'd0, m_re[63:16]};
            b_in.rem_im = {16'd0, m_im[63:16]};
            b_in.low_re = {m_re[15:0], 16'd0};
            b_in.low_im = {m_im[15:0], 16'd0};
            b_in.big_re = {16'd0, m_re} >= {norm, 16'd0};
            b_in.big_im = {16'd0, m_im} >= {norm, 16'd0};
         end
         KIND_PHASE: begin
            if (a_ai_ff == 0) begin
               b_in.ph_fix = 1'b1;
               sr = (a_ar_ff < 0) ? {1'b0, 32'(PI_Q)} : 33'd0;
            end else if (a_ar_ff < 0) begin
               if (a_ai_ff > 0) begin
                  x0 = y0;
                  y0 = -36'(a_ar_ff);
                  b_in.cz = HALF_PI_Q;
               end else begin
                  x0 = -y0;
                  y0 = 36'(a_ar_ff);
                  b_in.cz = -HALF_PI_Q;
               end
            end
         end
         default: begin
         end
      endcase
      b_in.cx     = x0;
      b_in.cy     = y0;
      b_in.fin_re = sr[31:0];
      b_in.fin_im = si[31:0];
      b_in.fin_st = (sr[32] || si[32]) ? ST_SAT : ST_OK;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_ff.vld <= 1'b0;
      end else if (en) begin
         b_ff <= b_in;
      end
   end

   assign req.ready  = en;
   assign first_cell = b_ff;

endmodule

@@ rtl/complex_arithmetic_unit_core.sv @@
// ----------------------------------------------------------------------------
// Complex arithmetic unit core
// Pipelined Q16.16 complex add, sub, mul, scale, conj, recip, div, mag, phase.
// ----------------------------------------------------------------------------
//   channel   direction   word
//   req       in          kind, a_real, a_imag, b_real, b_imag, alpha
//   rsp       out         res_real, res_imag, status
//
// One word enters per cycle unless the pipeline holds; each result passes, after its word
// is accepted, through two front-end stages, a chain of 32 cells (one quotient bit,
// root digit or rotation step per cell) and the output register to rsp.
// Reset clears the valid bits only.
// While a result waits with rsp.ready low the whole pipeline holds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "complex_arithmetic_unit_core_assert.svh"

module complex_arithmetic_unit_core (
   input  logic     clock,
   input  logic     reset,
   cau_req_if.sink  req,
   cau_rsp_if.source rsp
);
   import cau_pkg::*;

   cau_cell_type chain [0:CELL_COUNT];
   logic         adv;

   logic         rsp_vld_ff;
   data_type     rsp_re_ff, rsp_im_ff, rsp_re_in, rsp_im_in;
   status_type   rsp_st_ff, rsp_st_in;
   kind_type     rsp_kind_ff;

   logic [32:0]        dre, dim;
   logic signed [19:0] zc;

   function automatic logic [32:0] fin_div(input logic [31:0] q, input logic neg,
                                           input logic big);
      logic [32:0] r;
      logic [32:0] nq;
      nq = -{1'b0, q};
      if (big) r = {1'b1, neg ? DATA_MIN : DATA_MAX};
      else if (neg) r = (q > 32'h80000000) ? {1'b1, DATA_MIN} : {1'b0, nq[31:0]};
      else r = (q > 32'h7fffffff) ? {1'b1, DATA_MAX} : {1'b0, q};
      return r;
   endfunction

   assign adv = !rsp_vld_ff || rsp.ready;

   cau_prep u_prep (
      .clock      (clock),
      .reset      (reset),
      .en         (adv),
      .req        (req),
      .first_cell (chain[0])
   );

   for (genvar i = 0; i < CELL_COUNT; i++) begin : g_cell
      cau_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (adv),
         .step_idx  (5'(i)),
         .prev_cell (chain[i]),
         .next_cell (chain[i+1])
      );
   end

   always_comb begin
      dre       = fin_div(chain[CELL_COUNT].quo_re, chain[CELL_COUNT].neg_re,
                          chain[CELL_COUNT].big_re);
      dim       = fin_div(chain[CELL_COUNT].quo_im, chain[CELL_COUNT].neg_im,
                          chain[CELL_COUNT].big_im);
      zc        = chain[CELL_COUNT].cz;
      rsp_re_in = chain[CELL_COUNT].fin_re;
      rsp_im_in = chain[CELL_COUNT].fin_im;
      rsp_st_in = chain[CELL_COUNT].fin_st;
      case (chain[CELL_COUNT].kind)
         KIND_RECIP, KIND_DIV: begin
            if (chain[CELL_COUNT].dz) begin
               rsp_re_in = '0;
               rsp_im_in = '0;
               rsp_st_in = ST_DZ;
            end else begin
               rsp_re_in = dre[31:0];
               rsp_im_in = dim[31:0];
               rsp_st_in = (dre[32] || dim[32]) ? ST_SAT : ST_OK;
            end
         end
         KIND_MAG: begin
            rsp_im_in = '0;
            if (chain[CELL_COUNT].sq_root > 32'h7fffffff) begin
               rsp_re_in = DATA_MAX;
               rsp_st_in = ST_SAT;
            end else begin
               rsp_re_in = chain[CELL_COUNT].sq_root;
               rsp_st_in = ST_OK;
            end
         end
         KIND_PHASE: begin
            rsp_im_in = '0;
            rsp_st_in = ST_OK;
            if (!chain[CELL_COUNT].ph_fix) begin
               if (zc > PI_Q) zc = PI_Q;
               if (zc < -PI_Q) zc = -PI_Q;
               rsp_re_in = 32'(zc);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (adv) begin
         rsp_vld_ff  <= chain[CELL_COUNT].vld;
         rsp_re_ff   <= rsp_re_in;
         rsp_im_ff   <= rsp_im_in;
         rsp_st_ff   <= rsp_st_in;
         rsp_kind_ff <= chain[CELL_COUNT].kind;
      end
   end

   assign rsp.valid    = rsp_vld_ff;
   assign rsp.res_real = rsp_re_ff;
   assign rsp.res_imag = rsp_im_ff;
   assign rsp.status   = rsp_st_ff;

   `CAU_ASSERT(a_dz_zero, clock, reset, rsp_vld_ff && rsp_st_ff == ST_DZ |-> rsp_re_ff == 32'sd0 && rsp_im_ff == 32'sd0)
   `CAU_ASSERT(a_phase_range, clock, reset, rsp_vld_ff && rsp_kind_ff == KIND_PHASE |-> rsp_im_ff == 32'sd0 && rsp_re_ff <= 32'(PI_Q) && rsp_re_ff >= -32'(PI_Q))
   `CAU_ASSERT(a_mag_real, clock, reset, rsp_vld_ff && rsp_kind_ff == KIND_MAG |-> rsp_im_ff == 32'sd0 && rsp_st_ff != ST_DZ && rsp_re_ff >= 32'sd0)

endmodule

@@ tb/sv/complex_arithmetic_unit_core_checker.sv @@
// ----------------------------------------------------------------------------
// Complex arithmetic unit checker
// Watches the req and rsp channels, predicts one result word per accepted
// request word and compares every response word field by field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module complex_arithmetic_unit_core_checker (
   input  logic clock,
   input  logic reset,
   cau_req_if   req_mon,
   cau_rsp_if   rsp_mon,
   output int   fail_count,
   output int   pending_count,
   output int   checked_count
);
   import cau_pkg::*;

   typedef logic signed [129:0] wide_type;

   typedef struct packed {
      data_type   re;
      data_type   im;
      status_type st;
   } result_type;

   localparam longint PHASE_PI      = 205887;
   localparam longint PHASE_HALF_PI = 102944;
   localparam wide_type QUOT_CAP    = wide_type'(1) <<< 62;

   result_type expected_q[$];

   function automatic data_type clip(input wide_type v, inout logic ovf);
      if (v > wide_type'(DATA_MAX)) begin
         ovf = 1'b1;
         return DATA_MAX;
      end
      if (v < wide_type'(DATA_MIN)) begin
         ovf = 1'b1;
         return DATA_MIN;
      end
      return data_type'(v[WIDTH-1:0]);
   endfunction

   // truncated quotient of |num| * 2^sh / den, capped at 2^62, sign from neg
   function automatic wide_type scaled_quotient(input wide_type num, input int sh,
                                                input wide_type den, input logic neg);
      wide_type q;
      q = ((num < 0 ? -num : num) <<< sh) / den;
      if (q > QUOT_CAP) q = QUOT_CAP;
      return neg ? -q : q;
   endfunction

   function automatic wide_type int_sqrt(input logic [63:0] s);
      logic [63:0] root;
      logic [63:0] bitv;
      root = '0;
      bitv = 64'd1 << 62;
      while (bitv > s) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (s >= root + bitv) begin
            s = s - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return wide_type'({1'b0, root});
   endfunction

   function automatic int atan_step_value(input int i);
      int arc_table [16] = '{51472, 30385, 16055, 8150, 4091, 2047, 1024, 512,
                             256, 128, 64, 32, 16, 8, 4, 2};
      return arc_table[i];
   endfunction

   function automatic longint cordic_angle(input longint x, input longint y);
      longint z;
      longint t;
      longint dx;
      longint dy;
      longint step;
      z = 0;
      if (y == 0) return (x < 0) ? PHASE_PI : 0;
      if (x < 0) begin
         if (y > 0) begin
            t = x; x = y; y = -t; z = PHASE_HALF_PI;
         end else begin
            t = x; x = -y; y = t; z = -PHASE_HALF_PI;
         end
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         step = longint'(atan_step_value(i));
         if (y >= 0) begin
            x += dx; y -= dy; z += step;
         end else begin
            x -= dx; y += dy; z -= step;
         end
      end
      if (z > PHASE_PI) z = PHASE_PI;
      if (z < -PHASE_PI) z = -PHASE_PI;
      return z;
   endfunction

   function automatic result_type compute_result(input kind_type kind,
         input data_type ar_in, input data_type ai_in, input data_type br_in,
         input data_type bi_in, input data_type al_in);
      result_type r;
      logic ovf;
      wide_type ar, ai, br, bi, al, den, num;
      ar = ar_in; ai = ai_in; br = br_in; bi = bi_in; al = al_in;
      r = '0;
      ovf = 1'b0;
      case (kind)
         KIND_ADD: begin
            r.re = clip(ar + br, ovf);
            r.im = clip(ai + bi, ovf);
         end
         KIND_SUB: begin
            r.re = clip(ar - br, ovf);
            r.im = clip(ai - bi, ovf);
         end
         KIND_MUL: begin
            r.re = clip((ar * br - ai * bi) >>> FRAC_BITS, ovf);
            r.im = clip((ar * bi + ai * br) >>> FRAC_BITS, ovf);
         end
         KIND_SCALE: begin
            r.re = clip((ar * al) >>> FRAC_BITS, ovf);
            r.im = clip((ai * al) >>> FRAC_BITS, ovf);
         end
         KIND_CONJ: begin
            r.re = ar_in;
            r.im = clip(-ai, ovf);
         end
         KIND_RECIP: begin
            den = ar * ar + ai * ai;
            if (den == 0) r.st = ST_DZ;
            else begin
               r.re = clip(scaled_quotient(ar, 2 * FRAC_BITS, den, ar < 0), ovf);
               r.im = clip(scaled_quotient(ai, 2 * FRAC_BITS, den, ai > 0), ovf);
            end
         end
         KIND_DIV: begin
            den = br * br + bi * bi;
            if (den == 0) r.st = ST_DZ;
            else begin
               num = ar * br + ai * bi;
               r.re = clip(scaled_quotient(num, FRAC_BITS, den, num < 0), ovf);
               num = ai * br - ar * bi;
               r.im = clip(scaled_quotient(num, FRAC_BITS, den, num < 0), ovf);
            end
         end
         KIND_MAG: begin
            den = ar * ar + ai * ai;
            r.re = clip(int_sqrt(den[63:0]), ovf);
         end
         KIND_PHASE: begin
            r.re = clip(wide_type'(cordic_angle(longint'(ar_in), longint'(ai_in)))
                        <<< (FRAC_BITS - 16), ovf);
         end
         default: ;
      endcase
      if (ovf && r.st == ST_OK) r.st = ST_SAT;
      return r;
   endfunction

   result_type actual;
   result_type predicted;

   always @(posedge clock) begin
      if (reset) begin
         expected_q.delete();
         fail_count <= 0;
         checked_count <= 0;
         pending_count <= 0;
      end else begin
         if (req_mon.valid && req_mon.ready)
            expected_q.push_back(compute_result(req_mon.kind, req_mon.a_real,
               req_mon.a_imag, req_mon.b_real, req_mon.b_imag, req_mon.alpha));
         if (rsp_mon.valid && rsp_mon.ready) begin
            actual = '{rsp_mon.res_real, rsp_mon.res_imag, rsp_mon.status};
            checked_count <= checked_count + 1;
            if (expected_q.size() == 0) begin
               if (fail_count < 10)
                  $display("%0t: unexpected result word re=%0d im=%0d st=%0d",
                           $realtime, actual.re, actual.im, actual.st);
               fail_count <= fail_count + 1;
            end else begin
               predicted = expected_q.pop_front();
               if (actual !== predicted) begin
                  if (fail_count < 10)
                     $display("%0t: mismatch exp re=%0d im=%0d st=%0d got re=%0d im=%0d st=%0d",
                              $realtime, predicted.re, predicted.im, predicted.st,
                              actual.re, actual.im, actual.st);
                  fail_count <= fail_count + 1;
               end
            end
         end
         pending_count <= expected_q.size();
      end
   end

endmodule

@@ tb/sv/complex_arithmetic_unit_core_tb.sv @@
// ----------------------------------------------------------------------------
// Complex arithmetic unit testbench
// Drives directed corner words and random operation words in bursts, with a
// stalling receiver and one long hold-off; a side checker scores the results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module complex_arithmetic_unit_core_tb;
   import cau_pkg::*;

   localparam int       RANDOM_WORDS   = 630;
   localparam int       CYCLE_LIMIT    = 200000;
   localparam int       DRAIN_CYCLES   = 60;
   localparam kind_type KIND_LAST      = KIND_PHASE;
   localparam kind_type KIND_UNUSED_LO = 4'd9;
   localparam kind_type KIND_UNUSED_HI = 4'd15;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending_count;
   int   checked_count;
   int   sent_count;
   int   cycle_count;
   int   burst_left;
   int   hold_left;
   int   stall_mode;
   bit   long_hold_done;

   cau_req_if req_ch ();
   cau_rsp_if rsp_ch ();

   complex_arithmetic_unit_core dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   complex_arithmetic_unit_core_checker scoreboard (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_ch),
      .rsp_mon       (rsp_ch),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .checked_count (checked_count)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("status: fail");
         $finish;
      end
   end

   // receiver: changing stall modes plus one long hold-off
   always @(negedge clock) begin
      if (!reset && !long_hold_done && sent_count >= 300) begin
         long_hold_done <= 1'b1;
         hold_left <= 400;
         rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
         case (stall_mode)
            0: rsp_ch.ready <= 1'b1;
            1: rsp_ch.ready <= ($urandom_range(0, 9) < 7);
            2: rsp_ch.ready <= cycle_count[2];
            default: rsp_ch.ready <= ($urandom_range(0, 9) < 2);
         endcase
      end
   end

   task automatic send_word(input kind_type kind, input data_type ar, input data_type ai,
                            input data_type br, input data_type bi, input data_type al);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         if ($urandom_range(0, 2) != 0) begin
            @(negedge clock);
            req_ch.valid = 1'b0;
            repeat ($urandom_range(0, 12)) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_ch.valid  = 1'b1;
      req_ch.kind   = kind;
      req_ch.a_real = ar;
      req_ch.a_imag = ai;
      req_ch.b_real = br;
      req_ch.b_imag = bi;
      req_ch.alpha  = al;
      do @(posedge clock); while (!req_ch.ready);
      sent_count++;
   endtask

   function automatic data_type pick_value();
      case ($urandom_range(0, 5))
         0: return data_type'($urandom);
         1: return data_type'($urandom_range(0, 1) ? DATA_MAX : DATA_MIN);
         2: return data_type'($urandom_range(0, 4)) - 2;
         3: return data_type'($urandom_range(0, 1) ? 32'sd65536 : -32'sd65536);
         default: return data_type'($urandom_range(0, 1 << 20)) - (1 << 19);
      endcase
   endfunction

   initial begin
      data_type v0, v1, v2, v3, v4;
      kind_type k;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.kind = KIND_ADD;
      req_ch.a_real = '0;
      req_ch.a_imag = '0;
      req_ch.b_real = '0;
      req_ch.b_imag = '0;
      req_ch.alpha = '0;
      rsp_ch.ready = 1'b0;
      cycle_count = 0;
      sent_count = 0;
      burst_left = 0;
      hold_left = 0;
      stall_mode = 0;
      long_hold_done = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_word(KIND_ADD, DATA_MAX, DATA_MIN, DATA_MAX, DATA_MIN, 0);
      send_word(KIND_SUB, DATA_MIN, DATA_MAX, DATA_MAX, DATA_MIN, 0);
      send_word(KIND_ADD, 32'sd65536, -32'sd3, 32'sd7, 32'sd3, 0);
      send_word(KIND_MUL, DATA_MAX, DATA_MAX, DATA_MIN, DATA_MIN, 0);
      send_word(KIND_MUL, -32'sd1, 32'sd1, 32'sd1, 32'sd1, 0);
      send_word(KIND_MUL, 32'sd131072, -32'sd98304, 32'sd32768, 32'sd65536, 0);
      send_word(KIND_SCALE, DATA_MIN, DATA_MAX, 0, 0, DATA_MIN);
      send_word(KIND_SCALE, -32'sd5, 32'sd5, 0, 0, 32'sd1);
      send_word(KIND_CONJ, DATA_MIN, DATA_MIN, 0, 0, 0);
      send_word(KIND_CONJ, 32'sd12345, DATA_MAX, 0, 0, 0);
      send_word(KIND_RECIP, 0, 0, 0, 0, 0);
      send_word(KIND_RECIP, 32'sd1, 0, 0, 0, 0);
      send_word(KIND_RECIP, -32'sd65536, 32'sd65536, 0, 0, 0);
      send_word(KIND_RECIP, DATA_MIN, DATA_MIN, 0, 0, 0);
      send_word(KIND_DIV, 32'sd65536, 32'sd1, 0, 0, 0);
      send_word(KIND_DIV, DATA_MAX, DATA_MIN, 32'sd1, 0, 0);
      send_word(KIND_DIV, -32'sd300000, 32'sd70000, 32'sd131072, -32'sd65536, 0);
      send_word(KIND_MAG, DATA_MIN, DATA_MIN, 0, 0, 0);
      send_word(KIND_MAG, 32'sd196608, -32'sd262144, 0, 0, 0);
      send_word(KIND_PHASE, 0, 0, 0, 0, 0);
      send_word(KIND_PHASE, -32'sd65536, 0, 0, 0, 0);
      send_word(KIND_PHASE, -32'sd65536, 32'sd1, 0, 0, 0);
      send_word(KIND_PHASE, -32'sd65536, -32'sd1, 0, 0, 0);
      send_word(KIND_PHASE, DATA_MAX, DATA_MIN, 0, 0, 0);
      send_word(KIND_UNUSED_HI, DATA_MAX, DATA_MAX, DATA_MAX, DATA_MAX, DATA_MAX);

      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if ($urandom_range(0, 19) == 0) k = kind_type'($urandom_range(KIND_UNUSED_LO,
                                                                       KIND_UNUSED_HI));
         else k = kind_type'($urandom_range(KIND_ADD, KIND_LAST));
         v0 = pick_value();
         v1 = pick_value();
         v2 = pick_value();
         v3 = pick_value();
         v4 = pick_value();
         send_word(k, v0, v1, v2, v3, v4);
      end
      @(negedge clock);
      req_ch.valid = 1'b0;

      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d operation words over all nine operations and unused codes,",
               sent_count);
      $display("checked %0d result words with bursty input and stalled output",
               checked_count);
      if (fail_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/cau_pkg.sv
rtl/cau_if.sv
rtl/cau_cell.sv
rtl/cau_prep.sv
rtl/complex_arithmetic_unit_core.sv
tb/sv/complex_arithmetic_unit_core_checker.sv
tb/sv/complex_arithmetic_unit_core_tb.sv
